// ===== rtl/swtt_pkg.sv =====
`default_nettype none

package swtt_pkg;

    localparam int TIME_W     = 16;
    localparam int UPTIME_W   = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_TASK_W = 8;
    localparam int OUT_CNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_SLOT   = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_EV,
        ST_CN_RD,
        ST_CN_EV,
        ST_AP_RD,
        ST_AP_EV,
        ST_UPDATE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic idx_inc;
        logic eval_lookup;
        logic eval_count;
        logic eval_apply;
        logic apply_lookup;
        logic load_final;
    } swtt_cmd_t;

    typedef struct packed {
        logic new_tick;
        logic idx_last;
        logic out_free;
        logic fire;
    } swtt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/swtt_ram.sv =====
`default_nettype none

module swtt_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/swtt_ctrl.sv =====
`default_nettype none

module swtt_ctrl import swtt_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire swtt_stat_t stat,
    output swtt_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch   = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = stat.new_tick ? ST_CN_RD : ST_LK_RD;
                end
            end
            ST_LK_RD: state_next = ST_LK_EV;
            ST_LK_EV: begin
                cmd.eval_lookup = 1'b1;
                if (stat.idx_last) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_LK_RD;
                end
            end
            ST_CN_RD: state_next = ST_CN_EV;
            ST_CN_EV: begin
                cmd.eval_count = 1'b1;
                if (stat.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_AP_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CN_RD;
                end
            end
            ST_AP_RD: state_next = ST_AP_EV;
            ST_AP_EV: begin
                if (!stat.fire || stat.out_free) begin
                    cmd.eval_apply = 1'b1;
                    if (stat.idx_last) begin
                        state_next = ST_FINAL;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_AP_RD;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.apply_lookup = 1'b1;
                state_next       = ST_FINAL;
            end
            ST_FINAL: begin
                if (stat.out_free) begin
                    cmd.load_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/swtt_datapath.sv =====
`default_nettype none

module swtt_datapath import swtt_pkg::*; #(
    parameter int NUM_SLOTS    = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire swtt_cmd_t             cmd,
    output swtt_stat_t                 stat,
    input  wire logic [KIND_W-1:0]     in_kind,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ROW_W = TASK_ID_BITS + 3 * TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // item
    kind_t                   kind_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic [TIME_W-1:0]       ev_reg;
    logic [TIME_W-1:0]       tmo_reg;
    logic                    once_reg;
    logic [TIME_W-1:0]       ms_reg;

    // table control
    logic [IDX_W-1:0]        idx_reg;
    logic [NUM_SLOTS-1:0]    used_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [UPTIME_W-1:0]     uptime_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [TIME_W-1:0]       hit_left_reg;
    logic [TIME_W-1:0]       hit_reload_reg;
    logic                    free_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    status_t                 res_status_reg;
    logic [TIME_W-1:0]       res_rem_reg;

    // output register
    logic                    m_valid_reg;
    status_t                 m_status_reg;
    logic [TIME_W-1:0]       m_rem_reg;
    logic                    m_fired_reg;
    logic [OUT_TASK_W-1:0]   m_ftask_reg;
    logic [TIME_W-1:0]       m_fev_reg;
    logic                    m_last_reg;
    logic [OUT_CNT_W-1:0]    m_count_reg;
    logic [UPTIME_W-1:0]     m_uptime_reg;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ROW_W-1:0]        wr_data;
    logic [ROW_W-1:0]        rd_data;

    logic [TASK_ID_BITS-1:0] row_task;
    logic [TIME_W-1:0]       row_ev;
    logic [TIME_W-1:0]       row_left;
    logic [TIME_W-1:0]       row_reload;
    logic                    used_i;
    logic                    hit_i;
    logic [TIME_W-1:0]       new_left;
    logic [TIME_W-1:0]       after_left;
    logic                    fire_i;
    logic                    release_i;
    logic                    out_free;
    logic                    load_fire;

    swtt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign row_task   = rd_data[ROW_W-1 -: TASK_ID_BITS];
    assign row_ev     = rd_data[3*TIME_W-1 -: TIME_W];
    assign row_left   = rd_data[2*TIME_W-1 -: TIME_W];
    assign row_reload = rd_data[TIME_W-1:0];

    assign used_i     = used_reg[idx_reg];
    assign hit_i      = used_i && (row_task == task_reg) && (row_ev == ev_reg);
    assign new_left   = (row_left <= ms_reg) ? '0 : row_left - ms_reg;
    assign fire_i     = used_i && (new_left == '0) && (row_ev != '0);
    assign after_left = fire_i ? row_reload : new_left;
    assign release_i  = used_i && ((after_left == '0) || (row_ev == '0));

    assign out_free   = !m_valid_reg || m_tready;
    assign load_fire  = cmd.eval_apply && fire_i;

    assign stat.new_tick = (kind_t'(in_kind) == KIND_TICK);
    assign stat.idx_last = (idx_reg == LAST_IDX);
    assign stat.out_free = out_free;
    assign stat.fire     = fire_i;

    always_comb begin
        wr_en   = cmd.eval_apply && used_i;
        wr_addr = idx_reg;
        wr_data = {row_task, row_ev, after_left, row_reload};
        if (cmd.apply_lookup) begin
            case (kind_reg)
                KIND_START: begin
                    if (hit_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                        wr_data = {task_reg, ev_reg, tmo_reg,
                                   once_reg ? hit_reload_reg : tmo_reg};
                    end else if (free_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_reg;
                        wr_data = {task_reg, ev_reg, tmo_reg,
                                   once_reg ? {TIME_W{1'b0}} : tmo_reg};
                    end
                end
                KIND_STOP: begin
                    if (hit_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                        wr_data = {task_reg, {TIME_W{1'b0}}, hit_left_reg, hit_reload_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            used_reg    <= '0;
            count_reg   <= '0;
            uptime_reg  <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.latch) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                if (kind_t'(in_kind) == KIND_TICK) begin
                    uptime_reg <= uptime_reg + UPTIME_W'(in_data[56:41]);
                end
            end
            if (cmd.eval_lookup) begin
                if (!hit_reg && hit_i) begin
                    hit_reg <= 1'b1;
                end
                if (!free_reg && !used_i) begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.eval_count && release_i && (count_reg != '0)) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.eval_apply && release_i) begin
                used_reg[idx_reg] <= 1'b0;
            end
            if (cmd.apply_lookup && (kind_reg == KIND_START) && !hit_reg && free_reg) begin
                used_reg[free_idx_reg] <= 1'b1;
                count_reg              <= count_reg + 1'b1;
            end
            if (load_fire || cmd.load_final) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg       <= kind_t'(in_kind);
            task_reg       <= TASK_ID_BITS'(in_data[7:0]);
            ev_reg         <= in_data[23:8];
            tmo_reg        <= in_data[39:24];
            once_reg       <= in_data[40];
            ms_reg         <= in_data[56:41];
            res_status_reg <= STATUS_OK;
            res_rem_reg    <= '0;
        end
        if (cmd.eval_lookup) begin
            if (!hit_reg && hit_i) begin
                hit_idx_reg    <= idx_reg;
                hit_left_reg   <= row_left;
                hit_reload_reg <= row_reload;
            end
            if (!free_reg && !used_i) begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.apply_lookup) begin
            case (kind_reg)
                KIND_START: res_status_reg <= (hit_reg || free_reg) ? STATUS_OK
                                                                    : STATUS_NO_SLOT;
                KIND_STOP:  res_status_reg <= hit_reg ? STATUS_OK : STATUS_NOT_FOUND;
                KIND_READ:  res_rem_reg    <= hit_reg ? hit_left_reg : '0;
                default: ;
            endcase
        end
        if (load_fire) begin
            m_status_reg <= STATUS_OK;
            m_rem_reg    <= '0;
            m_fired_reg  <= 1'b1;
            m_ftask_reg  <= OUT_TASK_W'(row_task);
            m_fev_reg    <= row_ev;
            m_last_reg   <= 1'b0;
            m_count_reg  <= OUT_CNT_W'(count_reg);
            m_uptime_reg <= uptime_reg;
        end else if (cmd.load_final) begin
            m_status_reg <= res_status_reg;
            m_rem_reg    <= res_rem_reg;
            m_fired_reg  <= 1'b0;
            m_ftask_reg  <= '0;
            m_fev_reg    <= '0;
            m_last_reg   <= 1'b1;
            m_count_reg  <= OUT_CNT_W'(count_reg);
            m_uptime_reg <= uptime_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_fired_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_uptime_reg, m_count_reg, m_fev_reg, m_ftask_reg,
                       m_rem_reg, m_status_reg};

endmodule

`default_nettype wire

// ===== rtl/software_timer_table.sv =====
// Software timer table: NUM_SLOTS task timers keyed by task id and event bits.
// Input channel (s_axis_*): one item per handshake, tuser selects start, stop,
// read remaining or tick. Result channel (m_axis_*): one result per start,
// stop or read; a tick gives one fired result per expiring slot, in slot
// order, then a closing result with tlast high.
// Sequencing: start, stop and read walk every slot through the table RAM's
// read port, each slot in a read state and then an evaluate state on the
// registered read data, then pass an update state and a final state.
// A tick walks the table twice (first to settle the occupied count reported
// on every result, then to update and fire), and may wait on the receiver.
// One item is processed at a time; s_axis_tready is high only while idle.
// Results sit in an output register; while the receiver holds m_axis_tready
// low the walk pauses at the next expiring slot and nothing is lost.
// Reset (aresetn low, synchronous) frees every slot, clears the occupied
// count and the uptime, and drops any pending result.
`default_nettype none

module software_timer_table import swtt_pkg::*; #(
    parameter int NUM_SLOTS    = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // task_id[7:0], event_bits[23:8], timeout[39:24], one_shot[40],
    // elapsed_ms[56:41], zero[63:57]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  wire logic [KIND_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], remaining[17:2], fired_task[25:18], fired_event[41:26],
    // active_count[46:42], uptime_ms[78:47], zero[79]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // fired[0]
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast
);

    swtt_cmd_t  cmd;
    swtt_stat_t stat;

    swtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swtt_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_kind  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
